[design/bfs_pkg.sv]
// Package for the bit fingerprint similarity block: metric codes, register indexes, widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfs_pkg;
    localparam int CntW   = 13;
    localparam int ScoreW = 17;
    localparam int OutCnt = 12;
    localparam int IdxW   = 5;
    localparam int QW     = 17;

    localparam logic [2:0] MET_TANIMOTO = 3'd0;
    localparam logic [2:0] MET_DICE     = 3'd1;
    localparam logic [2:0] MET_TVERSKY  = 3'd2;
    localparam logic [2:0] MET_COSINE   = 3'd3;
    localparam logic [2:0] MET_KULC     = 3'd4;

    localparam logic [1:0] REG_METRIC = 2'd0;
    localparam logic [1:0] REG_ALPHA  = 2'd1;
    localparam logic [1:0] REG_BETA   = 2'd2;

    typedef struct packed {
        logic [2:0]      metric;
        logic [QW-1:0]   alpha;
        logic [QW-1:0]   beta;
        logic [CntW-1:0] a;
        logic [CntW-1:0] b;
        logic [CntW-1:0] c;
    } t_score_req;
endpackage
`default_nettype wire

[design/bfs_scorer.sv]
// Score back end: forms numerator and denominator, then a restoring divider, one
// quotient bit per cycle, or an integer square-root search. Depends on bfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfs_scorer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire bfs_pkg::t_score_req     i_req,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [bfs_pkg::ScoreW-1:0]   o_score
);
    import bfs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_DIV, S_SQRT, S_FIN} t_state;
    t_state r_state;

    localparam int NW = 48;
    // Quotient bits: result of (2n+d)/(2d) never needs more than 18 bits before saturation
    // check, but numerator can exceed den by 2^34; keep 36 quotient bits.
    localparam int QB = 36;

    t_score_req   r_req;
    logic [NW-1:0] r_num, r_den, r_rem;
    logic [QB-1:0] r_quo;
    logic [5:0]    r_cnt;
    logic [16:0]   r_lo, r_hi;
    logic [25:0]   r_ab;
    logic [63:0]   r_rhs;
    logic          r_zero;
    logic [ScoreW-1:0] r_score;
    logic [35:0]   r_tt;
    logic          r_sqph;

    logic [CntW-1:0] w_ac, w_bc;
    logic [16:0]     w_mid;
    logic [17:0]     w_t;
    logic [35:0]     w_t2;
    logic [25:0]     w_ab, w_c2, w_kn;
    logic [29:0]     w_ta, w_tb;
    logic [NW:0]     w_trial;
    logic [NW-1:0]   w_srem;

    always_comb begin
        w_ac = (r_req.a > r_req.c) ? r_req.a - r_req.c : '0;
        w_bc = (r_req.b > r_req.c) ? r_req.b - r_req.c : '0;
        w_ab = r_req.a * r_req.b;
        w_c2 = r_req.c * r_req.c;
        w_kn = r_req.c * (r_req.a + r_req.b);
        w_ta = r_req.alpha * w_ac;
        w_tb = r_req.beta * w_bc;
        w_mid = 17'((18'(r_lo) + 18'(r_hi) + 18'd1) >> 1);
        w_t = {w_mid, 1'b0} - 18'd1;
        w_t2 = w_t * w_t;
        w_srem = {r_rem[NW-2:0], r_num[NW-1]};
        w_trial = {1'b0, w_srem} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_req   <= i_req;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_cnt  <= 6'(NW);
                    case (r_req.metric)
                        MET_DICE: begin
                            r_num <= NW'({r_req.c, 18'd0} + 31'(r_req.a) + 31'(r_req.b));
                            r_den <= NW'({r_req.a + r_req.b, 1'b0});
                            r_zero <= (r_req.a == '0) && (r_req.b == '0);
                            r_state <= S_DIV;
                        end
                        MET_TVERSKY: begin
                            r_num <= NW'(r_req.c) << 32;
                            r_den <= NW'(w_ta) + NW'(w_tb) + (NW'(r_req.c) << 16);
                            r_zero <= 1'b0;
                            r_state <= S_MUL;
                        end
                        MET_COSINE: begin
                            r_ab  <= w_ab;
                            r_rhs <= {4'd0, w_c2, 34'd0};
                            r_lo  <= '0;
                            r_hi  <= 17'd65536;
                            r_sqph <= 1'b0;
                            r_zero <= (r_req.a == '0) || (r_req.b == '0);
                            r_state <= S_SQRT;
                        end
                        MET_KULC: begin
                            r_num <= NW'(w_kn);
                            r_den <= NW'(w_ab);
                            r_zero <= (r_req.a == '0) || (r_req.b == '0);
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_num <= NW'(r_req.c) << 16;
                            r_den <= NW'(r_req.a + r_req.b - r_req.c);
                            r_zero <= (r_req.c > r_req.a + r_req.b)
                                   || (r_req.a + r_req.b == r_req.c);
                            r_state <= S_MUL;
                        end
                    endcase
                end
                S_MUL: begin
                    // Turn num/den into (2num+den)/(2den); Kulczynski adds its 2^16 and /2.
                    if (r_req.metric == MET_KULC) begin
                        r_num <= (r_num << 17) + r_den + r_den;
                        r_den <= r_den << 2;
                    end else begin
                        r_num <= (r_num << 1) + r_den;
                        r_den <= r_den << 1;
                    end
                    if (r_req.metric == MET_TVERSKY) r_zero <= (r_den == '0);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= r_num << 1;
                    if (!w_trial[NW]) begin
                        r_rem <= w_trial[NW-1:0];
                        r_quo <= {r_quo[QB-2:0], 1'b1};
                    end else begin
                        r_rem <= w_srem;
                        r_quo <= {r_quo[QB-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) r_state <= S_FIN;
                end
                S_SQRT: begin
                    if (r_lo == r_hi) begin
                        r_quo   <= QB'(r_lo);
                        r_state <= S_FIN;
                    end else if (!r_sqph) begin
                        r_tt   <= w_t2;
                        r_sqph <= 1'b1;
                    end else begin
                        r_sqph <= 1'b0;
                        if (r_tt * r_ab <= r_rhs) r_lo <= w_mid;
                        else r_hi <= w_mid - 17'd1;
                    end
                end
                S_FIN: begin
                    if (r_zero) r_score <= '0;
                    else if (r_quo > QB'(65536)) r_score <= 17'd65536;
                    else r_score <= r_quo[ScoreW-1:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_score = r_score;
endmodule
`default_nettype wire

[design/bit_fingerprint_similarity.sv]
// Bit fingerprint similarity: top level with the query memory and the counters.
// Depends on bfs_pkg and bfs_scorer.
//
// Usage: configure metric, tversky_alpha and tversky_beta through the cfg channel while
// idle. Stream words on s_axis: tuser is action (0 load, 1 compare), tdata holds
// word_index then bits. A compare of the last word gives one word on m_axis:
// score, common_bits, candidate_bits. A word passes through the query memory read and
// write-back; the last word then runs the score unit, a division or, for cosine, a
// square-root search, during which input stalls. A stalled receiver holds the result
// and blocks new words until it is taken. Reset clears the query memory in one pass
// over its words, with input held off; config writes are taken during the pass.
`timescale 1ns / 1ps
`default_nettype none
module bit_fingerprint_similarity #(
    parameter int FP_BITS   = 2048,
    parameter int WORD_BITS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,  // word_index[4:0], bits[68:5], zeros
    input  wire         s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // score[16:0], common_bits[28:17], candidate_bits[40:29]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [16:0] i_cfg_data
);
    import bfs_pkg::*;

    localparam int NW = FP_BITS / WORD_BITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW = $clog2(WORD_BITS + 1);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RMW, S_SCORE, S_OUT} t_state;
    t_state r_state;

    logic [WORD_BITS-1:0] r_mem [NW];
    logic [WORD_BITS-1:0] r_rd;
    logic [AW-1:0]        r_clr, r_idx;
    logic [WORD_BITS-1:0] r_w;
    logic                 r_act, r_last;
    logic [CntW-1:0]      r_qc, r_cc, r_bc;
    logic [2:0]           r_metric;
    logic [QW-1:0]        r_alpha, r_beta;
    logic [47:0]          r_out;

    logic [IdxW-1:0]      w_idx;
    logic                 w_acc, w_sc_busy, w_sc_done, w_start;
    logic [ScoreW-1:0]    w_score;
    logic [PW-1:0]        w_pold, w_pnew, w_pand;
    logic [CntW-1:0]      w_cc0, w_bc0, w_ccs, w_bcs;
    t_score_req           w_req;

    function automatic logic [PW-1:0] pop(input logic [WORD_BITS-1:0] v);
        logic [PW-1:0] n;
        n = '0;
        for (int k = 0; k < WORD_BITS; k++) n = n + PW'(v[k]);
        return n;
    endfunction

    always_comb begin
        w_idx  = s_axis_tdata[IdxW-1:0];
        w_acc  = s_axis_tvalid && s_axis_tready;
        w_pold = pop(r_rd);
        w_pnew = pop(r_w);
        w_pand = pop(r_w & r_rd);
        w_cc0  = (r_idx == '0) ? '0 : r_cc;
        w_bc0  = (r_idx == '0) ? '0 : r_bc;
        w_ccs  = w_cc0 + CntW'(w_pand);
        w_bcs  = w_bc0 + CntW'(w_pnew);
        if (w_ccs > CntW'(FP_BITS)) w_ccs = CntW'(FP_BITS);
        if (w_bcs > CntW'(FP_BITS)) w_bcs = CntW'(FP_BITS);
        w_req = '{metric: r_metric, alpha: r_alpha, beta: r_beta,
                  a: r_qc, b: r_bc, c: r_cc};
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;
    assign w_start       = (r_state == S_SCORE) && !w_sc_busy && !w_sc_done && r_last;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) r_mem[r_clr] <= '0;
        else if (r_state == S_RMW && !r_act) r_mem[r_idx] <= r_w;
        if (w_acc) r_rd <= r_mem[w_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_qc     <= '0;
            r_cc     <= '0;
            r_bc     <= '0;
            r_metric <= MET_TANIMOTO;
            r_alpha  <= 17'd45875;
            r_beta   <= 17'd19661;
            r_last   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_METRIC: r_metric <= i_cfg_data[2:0];
                    REG_ALPHA:  r_alpha  <= i_cfg_data;
                    REG_BETA:   r_beta   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NW - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (w_acc && 32'(w_idx) < NW) begin
                    r_idx   <= w_idx[AW-1:0];
                    r_w     <= s_axis_tdata[IdxW +: WORD_BITS];
                    r_act   <= s_axis_tuser;
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    if (!r_act) begin
                        r_qc <= r_qc - CntW'(w_pold) + CntW'(w_pnew);
                        r_state <= S_IDLE;
                    end else begin
                        r_cc <= w_ccs;
                        r_bc <= w_bcs;
                        r_last <= (r_idx == AW'(NW - 1));
                        r_state <= (r_idx == AW'(NW - 1)) ? S_SCORE : S_IDLE;
                    end
                end
                S_SCORE: begin
                    r_last <= 1'b0;
                    if (w_sc_done) begin
                        r_out <= {7'd0, r_bc[OutCnt-1:0], r_cc[OutCnt-1:0], w_score};
                        r_cc <= '0;
                        r_bc <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    bfs_scorer u_scorer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_busy  (w_sc_busy),
        .o_done  (w_sc_done),
        .o_score (w_score)
    );
endmodule
`default_nettype wire

[design/bfs_checker.sv]
// Port-level checker for bit_fingerprint_similarity, bound to the top level.
// Depends on the top-level port list only.
`timescale 1ns / 1ps
`default_nettype none
module bfs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input taken while result pending");
    a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536)
        else $error("score above one");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule
bind bit_fingerprint_similarity bfs_checker u_chk (.*);
`default_nettype wire

[sim/tb_bit_fingerprint_similarity.sv]
// Testbench for bit_fingerprint_similarity: streams query loads and candidate compares,
// predicts every score in a scoreboard class and checks the results word by word.
// Depends on bfs_pkg and the design sources.
`timescale 1ns / 1ps
module tb_bit_fingerprint_similarity;
    import bfs_pkg::*;

    localparam int NWORDS   = 32;
    localparam int FP_MAX   = 2048;
    localparam int LIMIT    = 20000;
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPARE = 1'b1;

    typedef struct packed {
        logic [11:0] candidate_bits;
        logic [11:0] common_bits;
        logic [16:0] score;
    } t_score_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    int errors = 0;
    int idle_cycles = 0;
    int scores_seen = 0;
    bit hold_off = 1'b0;

    bit_fingerprint_similarity dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int popcount(input logic [63:0] v);
        int n = 0;
        for (int i = 0; i < 64; i++) n += v[i];
        return n;
    endfunction

    class similarity_scoreboard;
        logic [63:0] query_words[NWORDS];
        int          query_ones, common_ones, cand_ones;
        logic [2:0]  metric;
        logic [16:0] alpha, beta;
        t_score_word pending_scores[$];

        function new();
            foreach (query_words[i]) query_words[i] = '0;
            query_ones = 0; common_ones = 0; cand_ones = 0;
            metric = MET_TANIMOTO; alpha = 17'd45875; beta = 17'd19661;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [16:0] val);
            case (idx)
                REG_METRIC: metric = val[2:0];
                REG_ALPHA:  alpha = val;
                REG_BETA:   beta = val;
                default: ;
            endcase
        endfunction

        // Rounded half up and saturated at 1.0; a zero denominator scores zero.
        function automatic logic [16:0] q16_ratio(input longint unsigned num,
                                                  input longint unsigned den);
            longint unsigned q;
            if (den == 0) return '0;
            q = (2 * num + den) / (2 * den);
            return (q > 65536) ? 17'd65536 : q[16:0];
        endfunction

        // Largest s with (2s-1)^2 * ab <= (2 * 65536 * c)^2.
        function automatic logic [16:0] cosine_q16(input longint unsigned a,
                                                   input longint unsigned b,
                                                   input longint unsigned c);
            longint unsigned ab, rhs, lo, hi, mid, t;
            ab = a * b; rhs = (c * c) << 34; lo = 0; hi = 65536;
            if (ab == 0) return '0;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t = 2 * mid - 1;
                if (t * t * ab <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo[16:0];
        endfunction

        function automatic logic [16:0] similarity();
            longint unsigned a, b, c, ac, bc;
            a = query_ones; b = cand_ones; c = common_ones;
            case (metric)
                MET_DICE: return q16_ratio(c * 2 * 65536, a + b);
                MET_TVERSKY: begin
                    ac = (a > c) ? a - c : 0;
                    bc = (b > c) ? b - c : 0;
                    return q16_ratio(c << 32, alpha * ac + beta * bc + c * 65536);
                end
                MET_COSINE: return cosine_q16(a, b, c);
                MET_KULC: begin
                    if (a * b == 0) return '0;
                    return q16_ratio(c * 65536 * (a + b), 2 * a * b);
                end
                default: begin
                    if (c > a + b) return '0;
                    return q16_ratio(c * 65536, a + b - c);
                end
            endcase
        endfunction

        function void note_word(input logic action, input logic [4:0] idx,
                                input logic [63:0] bits);
            t_score_word r;
            if (action == ACT_LOAD) begin
                query_ones = query_ones - popcount(query_words[idx]) + popcount(bits);
                query_words[idx] = bits;
                return;
            end
            if (idx == 0) begin
                common_ones = 0; cand_ones = 0;
            end
            common_ones = common_ones + popcount(bits & query_words[idx]);
            cand_ones = cand_ones + popcount(bits);
            if (common_ones > FP_MAX) common_ones = FP_MAX;
            if (cand_ones > FP_MAX) cand_ones = FP_MAX;
            if (idx != NWORDS - 1) return;
            r.score = similarity();
            r.common_bits = common_ones[11:0];
            r.candidate_bits = cand_ones[11:0];
            pending_scores.insert(pending_scores.size(), r);
            common_ones = 0; cand_ones = 0;
        endfunction

        task check_score(input t_score_word got);
            t_score_word want;
            if (pending_scores.size() == 0) begin
                report("unexpected result", got.score, -1);
                return;
            end
            want = pending_scores.pop_front();
            if (got.score != want.score) report("score", got.score, want.score);
            if (got.common_bits != want.common_bits)
                report("common_bits", got.common_bits, want.common_bits);
            if (got.candidate_bits != want.candidate_bits)
                report("candidate_bits", got.candidate_bits, want.candidate_bits);
        endtask
    endclass

    similarity_scoreboard sb = new();

    // Receiver side: random stalls per word, plus a long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_score(t_score_word'(m_axis_tdata[40:0]));
            scores_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    bit quiet = 1'b0;

    // The valid stays high after a word is taken so that the next word can follow
    // directly; drain() drops it once the sender stops.
    task automatic send_word(input logic action, input logic [4:0] idx,
                             input logic [63:0] bits);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (!quiet && $urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= action;
        s_axis_tdata <= {3'b0, bits, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(action, idx, bits);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lets the block drain; a load or an unfinished compare may still be in flight.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_scores.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_bits(input int style);
        case (style)
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_candidate(input int style);
        for (int i = 0; i < NWORDS; i++) send_word(ACT_COMPARE, i[4:0], rand_bits(style));
    endtask

    task automatic load_query(input int style);
        for (int i = 0; i < NWORDS; i++) send_word(ACT_LOAD, i[4:0], rand_bits(style));
    endtask

    initial begin
        int n;
        int style;
        logic [16:0] weights[4];
        weights = '{17'd0, 17'd65536, 17'd1, 17'd45875};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty query, compares of zero and full words, all metrics,
        // partial candidates, rewrites and the unused metric codes.
        send_word(ACT_COMPARE, 5'd0, '0);
        send_word(ACT_COMPARE, 5'd31, '1);
        send_word(ACT_LOAD, 5'd3, '1);
        send_word(ACT_LOAD, 5'd3, 64'h5);
        send_word(ACT_LOAD, 5'd31, '1);
        send_word(ACT_COMPARE, 5'd3, '1);
        send_word(ACT_COMPARE, 5'd31, 64'hFFFF);
        send_word(ACT_COMPARE, 5'd31, '0);
        send_word(ACT_COMPARE, 5'd0, '1);
        send_word(ACT_COMPARE, 5'd0, '1);
        send_word(ACT_COMPARE, 5'd31, '1);
        drain();
        n = 0;
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_METRIC, m[16:0]);
            send_word(ACT_COMPARE, 5'd31, 64'hF0F0_0000_FFFF_000F);
            drain();
        end

        n = 0;
        while (n < 1500) begin
            write_reg(REG_METRIC, 17'($urandom_range(0, 4)));
            write_reg(REG_ALPHA, weights[$urandom_range(0, 3)]);
            write_reg(REG_BETA, ($urandom_range(0, 1) != 0) ? weights[$urandom_range(0, 3)]
                                                          : 17'($urandom_range(0, 65536)));
            if ($urandom_range(0, 3) == 0) begin
                load_query($urandom_range(0, 3));
                n += NWORDS;
            end
            for (int k = 0; k < 4; k++) begin
                style = $urandom_range(0, 9);
                if (style < 7) begin
                    send_candidate(style % 4);
                    n += NWORDS;
                end else begin
                    // Broken sequences: stray words, repeats and loads mid-candidate.
                    repeat ($urandom_range(1, 8)) begin
                        send_word(logic'($urandom_range(0, 1)), 5'($urandom), rand_bits(3));
                        n++;
                    end
                end
                if (k == 1 && n > 600 && n < 900) hold_off = 1'b1;
            end
            drain();
        end

        // Back-to-back candidates into a stalled receiver.
        quiet = 1'b1;
        hold_off = 1'b1;
        repeat (3) send_candidate(3);
        quiet = 1'b0;
        drain();
        write_reg(REG_METRIC, 17'(MET_TVERSKY));
        write_reg(REG_ALPHA, 17'd65536);
        write_reg(REG_BETA, 17'd0);
        send_candidate(2);
        drain();

        $display("Covered %0d scores over all metrics and weight extremes,", scores_seen);
        $display("with random stalls, a long receiver hold-off and broken candidates.");
        if (errors == 0 && sb.pending_scores.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
